>>> sv/lcm_pkg.sv
`timescale 1ns / 1ps

package lcm_pkg;

   localparam int POSITIONS_DEF = 1024;

   localparam int SLOPE_W    = 32;
   localparam int NEW_ICPT_W = 48;
   localparam int ICPT_W     = 62;
   localparam int VALUE_W    = 63;
   localparam int POS_W      = 10;
   localparam int TOP_W      = 10;

   localparam logic [TOP_W-1:0] TOP_RESET = 10'd1023;

   // sentinel line: slope 0, intercept 2^60
   localparam logic signed [ICPT_W-1:0] EMPTY_ICPT = ICPT_W'(64'sd1 <<< 60);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef struct packed {
      logic clear_wr;
      logic start;
      logic rd;
      logic eval;
      logic decide;
      logic finish;
      logic load_rsp;
   } lcm_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic range_empty;
      logic is_query;
      logic hit;
   } lcm_status_type;

endpackage

>>> sv/lcm_ram.sv
`timescale 1ns / 1ps

module lcm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/lcm_ctrl.sv
`timescale 1ns / 1ps

module lcm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  lcm_pkg::lcm_status_type status,
   output lcm_pkg::lcm_cmd_type    cmd
);

   import lcm_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_READ   = 7'b0000100,
      ST_EVAL   = 7'b0001000,
      ST_DECIDE = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            if (status.range_empty) begin
               state_in = status.is_query ? ST_FINISH : ST_IDLE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = (status.is_query && status.hit) ? ST_DONE : ST_READ;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> (state_ff != ST_CLEAR))
      else $error("clearing pass re-entered");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result shown without a finished query");

endmodule

>>> sv/lcm_datapath.sv
`timescale 1ns / 1ps

module lcm_datapath #(
   parameter int POSITIONS = lcm_pkg::POSITIONS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lcm_pkg::lcm_cmd_type                   cmd,
   output lcm_pkg::lcm_status_type                status,
   input  logic                                   csr_wr,
   input  logic [lcm_pkg::TOP_W-1:0]              csr_value,
   input  logic                                   req_command,
   input  logic signed [lcm_pkg::SLOPE_W-1:0]     req_slope,
   input  logic signed [lcm_pkg::NEW_ICPT_W-1:0]  req_intercept,
   input  logic [lcm_pkg::POS_W-1:0]              req_position,
   output logic signed [lcm_pkg::SLOPE_W-1:0]     rsp_slope,
   output logic signed [lcm_pkg::ICPT_W-1:0]      rsp_intercept,
   output logic signed [lcm_pkg::VALUE_W-1:0]     rsp_value
);

   import lcm_pkg::*;

   localparam int IDX_W = $clog2(POSITIONS);
   localparam int BND_W = ((IDX_W > POS_W) ? IDX_W : POS_W) + 2;
   localparam int VAL_W = 64;

   localparam logic signed [VAL_W-1:0] VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] EMPTY_VAL = VAL_W'(EMPTY_ICPT);
   localparam logic signed [BND_W-1:0] ROOT_MAX  = BND_W'(POSITIONS - 1);
   localparam logic signed [BND_W-1:0] ONE       = BND_W'(1);

   function automatic logic signed [VAL_W-1:0] line_val(
      input logic signed [SLOPE_W-1:0] s,
      input logic signed [ICPT_W-1:0]  c,
      input logic signed [BND_W-1:0]   p
   );
      logic signed [SLOPE_W+BND_W-1:0] prod;
      prod = s * p;
      return VAL_W'(prod) + VAL_W'(c);
   endfunction

   logic [TOP_W-1:0]            top_index_ff;
   logic [IDX_W-1:0]            clr_cnt_ff;
   logic                        cmd_ff;
   logic signed [SLOPE_W-1:0]   cs_ff, ss_ff, best_s_ff;
   logic signed [ICPT_W-1:0]    ci_ff, si_ff, best_i_ff;
   logic signed [VAL_W-1:0]     best_v_ff;
   logic signed [VAL_W-1:0]     v_cm_ff, v_sm_ff, v_cl_ff, v_sl_ff;
   logic [POS_W-1:0]            x_ff;
   logic signed [BND_W-1:0]     lo_ff, hi_ff, mid_ff;

   logic signed [BND_W-1:0]     top_ext, root_right, x_ext, mid_sum, mid_comb, pt_a;
   logic                        is_query, swap, take, take_empty, go_left;
   logic                        ram_we;
   logic [IDX_W-1:0]            ram_waddr;
   logic [SLOPE_W-1:0]          wr_slope, rd_slope_raw;
   logic [ICPT_W-1:0]           wr_icpt, rd_icpt_raw;
   logic signed [SLOPE_W-1:0]   rd_slope;
   logic signed [ICPT_W-1:0]    rd_icpt;

   assign top_ext    = BND_W'(top_index_ff);
   assign root_right = (top_ext > ROOT_MAX) ? ROOT_MAX : top_ext;
   assign x_ext      = BND_W'(x_ff);
   assign mid_sum    = lo_ff + hi_ff;
   assign mid_comb   = mid_sum >>> 1;
   assign is_query   = (cmd_ff == CMD_QUERY);
   assign pt_a       = is_query ? x_ext : mid_ff;
   assign rd_slope   = $signed(rd_slope_raw);
   assign rd_icpt    = $signed(rd_icpt_raw);

   assign swap       = (v_cm_ff < v_sm_ff);
   // deeper node wins a tie
   assign take       = (v_sm_ff <= best_v_ff);
   assign take_empty = (EMPTY_VAL <= best_v_ff);
   assign go_left    = is_query ? (x_ext < mid_ff)
                                : (swap ? (v_sl_ff < v_cl_ff) : (v_cl_ff < v_sl_ff));

   assign ram_we    = cmd.clear_wr || (cmd.decide && (cmd_ff == CMD_INSERT) && swap);
   assign ram_waddr = cmd.clear_wr ? clr_cnt_ff : mid_ff[IDX_W-1:0];
   assign wr_slope  = cmd.clear_wr ? '0 : cs_ff;
   assign wr_icpt   = cmd.clear_wr ? EMPTY_ICPT : ci_ff;

   lcm_ram #(.WIDTH(SLOPE_W), .DEPTH(POSITIONS)) u_slope_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wr_slope),
      .rd_addr (mid_comb[IDX_W-1:0]),
      .rd_data (rd_slope_raw)
   );

   lcm_ram #(.WIDTH(ICPT_W), .DEPTH(POSITIONS)) u_icpt_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wr_icpt),
      .rd_addr (mid_comb[IDX_W-1:0]),
      .rd_data (rd_icpt_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         top_index_ff <= TOP_RESET;
         clr_cnt_ff   <= '0;
      end else begin
         if (csr_wr) begin
            top_index_ff <= csr_value;
         end
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cmd_ff    <= req_command;
         cs_ff     <= req_slope;
         ci_ff     <= ICPT_W'(req_intercept);
         x_ff      <= req_position;
         lo_ff     <= '0;
         hi_ff     <= root_right;
         best_v_ff <= VAL_MAX;
      end
      if (cmd.rd) begin
         mid_ff <= mid_comb;
      end
      if (cmd.eval) begin
         ss_ff   <= rd_slope;
         si_ff   <= rd_icpt;
         v_cm_ff <= line_val(cs_ff, ci_ff, mid_ff);
         v_sm_ff <= line_val(rd_slope, rd_icpt, pt_a);
         v_cl_ff <= line_val(cs_ff, ci_ff, lo_ff);
         v_sl_ff <= line_val(rd_slope, rd_icpt, lo_ff);
      end
      if (cmd.decide) begin
         if (go_left) begin
            hi_ff <= mid_ff - ONE;
         end else begin
            lo_ff <= mid_ff + ONE;
         end
         if (is_query) begin
            if (take) begin
               best_s_ff <= ss_ff;
               best_i_ff <= si_ff;
               best_v_ff <= v_sm_ff;
            end
         end else if (swap) begin
            cs_ff <= ss_ff;
            ci_ff <= si_ff;
         end
      end
      // walk ended on an empty range: sentinel is deepest
      if (cmd.finish && take_empty) begin
         best_s_ff <= '0;
         best_i_ff <= EMPTY_ICPT;
         best_v_ff <= EMPTY_VAL;
      end
      if (cmd.load_rsp) begin
         rsp_slope     <= best_s_ff;
         rsp_intercept <= best_i_ff;
         rsp_value     <= VALUE_W'(best_v_ff);
      end
   end

   assign status.clear_last  = (clr_cnt_ff == IDX_W'(POSITIONS - 1));
   assign status.range_empty = (lo_ff > hi_ff);
   assign status.is_query    = is_query;
   assign status.hit         = (mid_ff == x_ext);

   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (ram_we && !cmd.clear_wr) |-> (cmd_ff == CMD_INSERT))
      else $error("store written during a query");

   a_eval_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> (lo_ff <= hi_ff))
      else $error("node evaluated on an empty range");

   a_range_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> ((lo_ff >= $past(lo_ff)) && (hi_ff <= $past(hi_ff))))
      else $error("walk range grew");

endmodule

>>> sv/li_chao_min_line_store_unit.sv
`timescale 1ns / 1ps

// Li Chao tree (minimum) over positions 0..top_index (capped at POSITIONS-1),
// one line per node stored at the node's midpoint. Command 0 inserts a line
// and returns nothing; command 1 returns the line lowest at the given position
// (deeper node wins ties, the sentinel slope 0 / intercept 2^60 when nothing
// lower is on the path). One item is in flight at a time: each tree level
// visited goes through a store read, a registered line evaluation and a
// compare and swap or best update. An insert is accepted, walks L levels and
// ends on an empty-range check. A query that runs to the bottom adds the
// sentinel step and the result load; one that stops at its position after k
// levels adds only the result load. L is up to 11 for 1024 positions. The
// result load waits while the previous item still sits unread in the output
// register. After reset the store is swept to the sentinel line with
// req_tready low; csr writes are taken at any time and belong only to idle
// periods.

module li_chao_min_line_store_unit #(
   parameter int POSITIONS = lcm_pkg::POSITIONS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // new_slope[31:0], new_intercept[79:32], position[89:80], zero fill
   input  logic [95:0]               req_tdata,
   // command[0]
   input  logic [0:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // best_slope[31:0], best_intercept[93:32], best_value[156:94], zero fill
   output logic [159:0]              rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [lcm_pkg::TOP_W-1:0] csr_data
);

   import lcm_pkg::*;

   lcm_cmd_type               cmd;
   lcm_status_type            status;
   logic signed [SLOPE_W-1:0] rsp_slope;
   logic signed [ICPT_W-1:0]  rsp_intercept;
   logic signed [VALUE_W-1:0] rsp_value;

   assign csr_ready = 1'b1;

   lcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lcm_datapath #(.POSITIONS(POSITIONS)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_wr        (csr_valid && csr_ready),
      .csr_value     (csr_data),
      .req_command   (req_tuser[0]),
      .req_slope     ($signed(req_tdata[31:0])),
      .req_intercept ($signed(req_tdata[79:32])),
      .req_position  (req_tdata[89:80]),
      .rsp_slope     (rsp_slope),
      .rsp_intercept (rsp_intercept),
      .rsp_value     (rsp_value)
   );

   assign rsp_tdata = {3'b000, rsp_value, rsp_intercept, rsp_slope};

endmodule
